>>> sv/skls_pkg.sv
package skls_pkg;

    // Fixed field widths of the data and configuration paths, and the reset value of k.
    localparam int DATA_W     = 32;
    localparam int RANK_W     = 5;
    localparam int RANK_RESET = 16;

    // Per-cell control from the top level to one cell of the chain.
    typedef struct packed {
        logic load;     // an item is transferred this cycle
        logic insert;   // store not yet full: sorted insertion mode
        logic filled;   // this slot holds a kept value
        logic in_rank;  // this slot lies below the effective rank
    } cell_ctrl_t;

    // What a cell shows its neighbors: its value and its two decisions.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     ins_flag;  // slot moves up (or takes the item) on insert
        logic                     rep_flag;  // slot moves down (or takes the item) on replace
    } cell_link_t;

endpackage

>>> sv/skls_cell.sv
module skls_cell (
    input  logic                                  aclk,
    input  skls_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [skls_pkg::DATA_W-1:0]    item_value,
    input  skls_pkg::cell_link_t                  lower_link,
    input  skls_pkg::cell_link_t                  upper_link,
    output skls_pkg::cell_link_t                  link_out,
    output logic signed [skls_pkg::DATA_W-1:0]    value_next
);

    logic signed [skls_pkg::DATA_W-1:0] value_reg;
    logic                               ins_flag;
    logic                               rep_flag;

    // An empty slot counts as larger than any item; only ranked slots may be replaced.
    assign ins_flag = !ctrl.filled || (value_reg > item_value);
    assign rep_flag = ctrl.in_rank && (value_reg < item_value);

    assign link_out.value    = value_reg;
    assign link_out.ins_flag = ins_flag;
    assign link_out.rep_flag = rep_flag;

    // Insertion shifts larger values up one slot; replacement shifts smaller ones down.
    always_comb begin
        value_next = value_reg;
        if (ctrl.insert) begin
            if (ins_flag) begin
                value_next = lower_link.ins_flag ? lower_link.value : item_value;
            end
        end else begin
            if (rep_flag) begin
                value_next = upper_link.rep_flag ? upper_link.value : item_value;
            end
        end
    end

    // The slot value is payload and needs no reset.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            value_reg <= value_next;
        end
    end

endmodule

>>> sv/streaming_kth_largest_select.sv
// Streaming k-th largest selection.
// Values arrive on the s_ channel (s_value, s_last) with a valid/ready handshake.
// A row of K_MAX compare-and-shift cells keeps the k largest values of the
// current set in ascending order; every transfer updates all cells in the same cycle.
// On a transfer with s_last high, the smallest kept value appears on
// m_kth_largest through a register, with m_valid_res high when at least k values
// arrived in the set (otherwise m_kth_largest is zero); the set then restarts.
// Throughput is one item per cycle while s_ready is high.
// The result sits in an output register: s_ready stays high while that register
// is empty or being taken, so a stalled receiver holds off input only once a
// result is waiting. Items without s_last never need the output register but
// wait along with the others.
// cfg_wr_en/cfg_wr_data write k (0 acts as 1, above K_MAX acts as K_MAX) and
// empty the store; write only while idle.
// After reset k is 16 (or K_MAX if smaller), the store is empty and no result
// is pending.
module streaming_kth_largest_select #(
    parameter int K_MAX = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [skls_pkg::DATA_W-1:0]    s_value,
    input  logic                                  s_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [skls_pkg::DATA_W-1:0]    m_kth_largest,
    output logic                                  m_valid_res,
    input  logic                                  cfg_wr_en,
    input  logic [skls_pkg::RANK_W-1:0]           cfg_wr_data
);

    localparam int CW      = $clog2(K_MAX + 1);
    localparam int RESET_K = (skls_pkg::RANK_RESET > K_MAX) ? K_MAX : skls_pkg::RANK_RESET;

    logic [CW-1:0]                       rank_reg;
    logic [CW-1:0]                       rank_next;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic [CW-1:0]                       count_inc;
    logic                                m_valid_reg;
    logic                                m_valid_res_reg;
    logic signed [skls_pkg::DATA_W-1:0]  m_kth_largest_reg;
    logic                                transfer;
    logic                                insert_mode;
    logic [31:0]                         rank_wide;
    skls_pkg::cell_ctrl_t                ctrl      [K_MAX];
    skls_pkg::cell_link_t                links     [K_MAX];
    logic signed [skls_pkg::DATA_W-1:0]  cell_next [K_MAX];
    skls_pkg::cell_link_t                end_link;

    assign transfer    = s_valid && s_ready;
    assign s_ready     = !m_valid_reg || m_ready;
    assign insert_mode = count_reg < rank_reg;
    assign count_inc   = count_reg + CW'(1);

    assign m_valid       = m_valid_reg;
    assign m_valid_res   = m_valid_res_reg;
    assign m_kth_largest = m_kth_largest_reg;

    // Neighbor seen past either end of the row: never shifts in.
    assign end_link = '0;

    // Effective rank of a configuration write.
    always_comb begin
        rank_wide = 32'(cfg_wr_data);
        if (rank_wide == 32'd0) begin
            rank_wide = 32'd1;
        end else if (rank_wide > 32'(K_MAX)) begin
            rank_wide = 32'(K_MAX);
        end
        rank_next = rank_wide[CW-1:0];
    end

    // Kept-value count: grows while filling, clears at the end of a set.
    always_comb begin
        count_next = count_reg;
        if (transfer) begin
            if (s_last) begin
                count_next = '0;
            end else if (insert_mode) begin
                count_next = count_inc;
            end
        end
    end

    // Row of cells with per-slot control.
    for (genvar i = 0; i < K_MAX; i++) begin : g_cell
        skls_pkg::cell_link_t lower_link;
        skls_pkg::cell_link_t upper_link;

        assign ctrl[i].load    = transfer;
        assign ctrl[i].insert  = insert_mode;
        assign ctrl[i].filled  = CW'(i) < count_reg;
        assign ctrl[i].in_rank = CW'(i) < rank_reg;

        if (i == 0) begin : g_lo_end
            assign lower_link = end_link;
        end else begin : g_lo
            assign lower_link = links[i-1];
        end

        if (i == K_MAX - 1) begin : g_hi_end
            assign upper_link = end_link;
        end else begin : g_hi
            assign upper_link = links[i+1];
        end

        skls_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl[i]),
            .item_value (s_value),
            .lower_link (lower_link),
            .upper_link (upper_link),
            .link_out   (links[i]),
            .value_next (cell_next[i])
        );
    end

    // Rank and count registers; a rank write starts a new set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg  <= CW'(RESET_K);
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            rank_reg  <= rank_next;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Output register: loaded with the new minimum on the last item of a set, or zero when under k values arrived.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (transfer && s_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (transfer && s_last) begin
            if (!insert_mode || (count_inc >= rank_reg)) begin
                m_valid_res_reg   <= 1'b1;
                m_kth_largest_reg <= cell_next[0];
            end else begin
                m_valid_res_reg   <= 1'b0;
                m_kth_largest_reg <= '0;
            end
        end
    end

endmodule
